// ----- design/cdhp_pkg.sv -----
package cdhp_pkg;

   localparam int HEADER_BYTES        = 55;
   localparam int MAX_PAYLOAD_DEFAULT = 65535;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int TOTAL_W             = 17;
   localparam int CSR_INDEX_W         = 1;
   localparam int CSR_DATA_W          = 16;

   localparam logic [7:0]  COMMAND_RESET       = 8'd0;
   localparam logic [15:0] MAX_FIELD_LEN_RESET = 16'd512;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COMMAND_CODE,
      CSR_MAX_FIELD_LEN
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_SHORT,
      ST_BAD_COMMAND,
      ST_BELOW_HEADER,
      ST_FIELD_LONG,
      ST_SPAN_OUT,
      ST_HEADER_LEN,
      ST_TOO_LONG
   } status_type;

   // header bytes 1..54, byte n at element n
   typedef logic [HEADER_BYTES-1:1][7:0] hdr_raw_type;

   typedef struct packed {
      logic               we;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  wdata;
   } csr_wr_type;

   typedef struct packed {
      logic               cmd_ok;
      logic [TOTAL_W-1:0] total;
      hdr_raw_type        raw;
   } job_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [31:0]         flags;
      logic signed [31:0]  channel;
      logic signed [63:0]  cmt_version;
      logic signed [63:0]  transaction_id;
      logic signed [63:0]  transaction_seq;
      logic [63:0]         tenant;
      logic [15:0]         header_length;
      logic [31:0]         client_span;
      logic [31:0]         token_span;
      logic [31:0]         stream_span;
   } rsp_type;

endpackage

// ----- design/cdhp_ifs.sv -----
interface cdhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface cdhp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic [31:0]        flags;
   logic signed [31:0] channel;
   logic signed [63:0] cmt_version;
   logic signed [63:0] transaction_id;
   logic signed [63:0] transaction_seq;
   logic [63:0]        tenant;
   logic [15:0]        header_length;
   logic [31:0]        client_span;
   logic [31:0]        token_span;
   logic [31:0]        stream_span;

   modport source (output valid, status, flags, channel, cmt_version, transaction_id,
                   transaction_seq, tenant, header_length, client_span, token_span,
                   stream_span, input ready);
   modport sink   (input valid, status, flags, channel, cmt_version, transaction_id,
                   transaction_seq, tenant, header_length, client_span, token_span,
                   stream_span, output ready);
endinterface

// ----- design/cdc_dump_header_parser_unit.sv -----
// channel   dir  beat payload                                   handshake
// req_chan  in   data_byte[8], last_byte[1]                     valid/ready
// rsp_chan  out  status[3], flags..stream_span (10 fields)      valid/ready
// csr_*     in   csr_index[1], csr_wdata[16]                    csr_we, no wait
//
// One byte beat per cycle while req_chan.ready is high. A result passes through the result
// queue and then the output register before it is valid.
// The header byte store is not cleared by reset.
// req_chan.ready drops only while the result queue (two entries by default) is full.
module cdc_dump_header_parser_unit #(
   parameter int MAX_PAYLOAD = cdhp_pkg::MAX_PAYLOAD_DEFAULT,
   parameter int QUEUE_DEPTH = cdhp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   cdhp_req_if.sink                            req_chan,
   cdhp_rsp_if.source                          rsp_chan,
   input  logic                                csr_we,
   input  logic [cdhp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cdhp_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int JOB_W = $bits(cdhp_pkg::job_type);

   cdhp_pkg::csr_wr_type csr;
   cdhp_pkg::job_type    push_job, pop_job;
   logic                 q_push, q_full, q_pop, q_valid;
   logic [JOB_W-1:0]     q_rd_data;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   cdhp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .csr      (csr),
      .job_full (q_full),
      .job_push (q_push),
      .job      (push_job)
   );

   cdhp_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .rd_data   (q_rd_data),
      .not_empty (q_valid)
   );

   assign pop_job = cdhp_pkg::job_type'(q_rd_data);

   cdhp_back #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .job_valid (q_valid),
      .job       (pop_job),
      .job_pop   (q_pop),
      .rsp       (rsp_chan)
   );

   a_reset_no_rsp: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

   a_ok_header_len: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.status == cdhp_pkg::ST_OK
      |-> rsp_chan.header_length == 16'(cdhp_pkg::HEADER_BYTES))
      else $error("ok status with wrong header length");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status == cdhp_pkg::ST_SHORT ||
                         rsp_chan.status == cdhp_pkg::ST_BAD_COMMAND)
      |-> rsp_chan.flags == '0 && rsp_chan.header_length == '0 &&
          rsp_chan.stream_span == '0)
      else $error("rejected packet carries header fields");

endmodule

// ----- design/cdhp_front.sv -----
module cdhp_front #(
   parameter int MAX_PAYLOAD = cdhp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   cdhp_req_if.sink             req,
   input  cdhp_pkg::csr_wr_type csr,
   input  logic                 job_full,
   output logic                 job_push,
   output cdhp_pkg::job_type    job
);

   localparam int POS_W   = $clog2(MAX_PAYLOAD + 2);
   localparam int TOTAL_W = cdhp_pkg::TOTAL_W;
   localparam int HDR_N   = cdhp_pkg::HEADER_BYTES;
   localparam logic [POS_W-1:0] POS_SAT = POS_W'(MAX_PAYLOAD + 1);

   logic [POS_W-1:0] pos_ff, pos_in, pos_inc;
   logic             cmd_ok_ff, cmd_ok_in, cmd_ok_now;
   logic [7:0]       command_ff, command_in;
   logic [7:0]       store_ff [1:HDR_N-1];
   logic             accept;
   logic             first;

   assign req.ready = !job_full;
   assign accept    = req.valid && req.ready;
   assign first     = (pos_ff == '0);
   assign pos_inc   = (pos_ff < POS_SAT) ? pos_ff + POS_W'(1) : pos_ff;
   assign cmd_ok_now = first ? (req.data_byte == command_ff) : cmd_ok_ff;

   always_comb begin
      command_in = command_ff;
      if (csr.we) begin
         case (csr.index)
            cdhp_pkg::CSR_COMMAND_CODE: command_in = csr.wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      pos_in    = pos_ff;
      cmd_ok_in = cmd_ok_ff;
      if (accept) begin
         pos_in    = req.last_byte ? '0 : pos_inc;
         cmd_ok_in = cmd_ok_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         cmd_ok_ff  <= 1'b0;
         command_ff <= cdhp_pkg::COMMAND_RESET;
      end else begin
         pos_ff     <= pos_in;
         cmd_ok_ff  <= cmd_ok_in;
         command_ff <= command_in;
      end
   end

   // header bytes; the byte arriving now bypasses into the job
   for (genvar i = 1; i < HDR_N; i++) begin : g_store
      always_ff @(posedge clock) begin
         if (accept && pos_ff == POS_W'(i)) begin
            store_ff[i] <= req.data_byte;
         end
      end
      assign job.raw[i] = (pos_ff == POS_W'(i)) ? req.data_byte : store_ff[i];
   end

   assign job.cmd_ok = cmd_ok_now;
   assign job.total  = TOTAL_W'(pos_inc);
   assign job_push   = accept && req.last_byte;

endmodule

// ----- design/cdhp_queue.sv -----
module cdhp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = cdhp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             not_empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue pop while empty");

endmodule

// ----- design/cdhp_back.sv -----
module cdhp_back #(
   parameter int MAX_PAYLOAD = cdhp_pkg::MAX_PAYLOAD_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cdhp_pkg::csr_wr_type csr,
   input  logic                 job_valid,
   input  cdhp_pkg::job_type    job,
   output logic                 job_pop,
   cdhp_rsp_if.source           rsp
);

   localparam int TOTAL_W = cdhp_pkg::TOTAL_W;
   localparam logic [TOTAL_W-1:0] HDR_TOTAL = TOTAL_W'(cdhp_pkg::HEADER_BYTES);
   localparam logic [TOTAL_W-1:0] MAX_TOTAL = TOTAL_W'(MAX_PAYLOAD);
   localparam logic [15:0]        HDR_LEN   = 16'(cdhp_pkg::HEADER_BYTES);

   logic [15:0]          max_len_ff, max_len_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   cdhp_pkg::rsp_type    rsp_ff, rsp_in;
   cdhp_pkg::status_type st;
   logic [15:0]          hlen;
   logic [15:0]          off [3];
   logic [15:0]          len [3];
   logic [2:0]           len_bad, span_bad;

   assign hlen   = job.raw[42:41];
   assign off[0] = job.raw[44:43];
   assign len[0] = job.raw[46:45];
   assign off[1] = job.raw[48:47];
   assign len[1] = job.raw[50:49];
   assign off[2] = job.raw[52:51];
   assign len[2] = job.raw[54:53];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         len_bad[k]  = (len[k] > max_len_ff);
         span_bad[k] = (TOTAL_W'(off[k]) + TOTAL_W'(len[k])) > job.total;
      end
   end

   always_comb begin
      if (job.total < HDR_TOTAL) begin
         st = cdhp_pkg::ST_SHORT;
      end else if (!job.cmd_ok) begin
         st = cdhp_pkg::ST_BAD_COMMAND;
      end else if (job.total < TOTAL_W'(hlen)) begin
         st = cdhp_pkg::ST_BELOW_HEADER;
      end else if (len_bad != '0) begin
         st = cdhp_pkg::ST_FIELD_LONG;
      end else if (span_bad != '0) begin
         st = cdhp_pkg::ST_SPAN_OUT;
      end else if (hlen != HDR_LEN) begin
         st = cdhp_pkg::ST_HEADER_LEN;
      end else if (job.total > MAX_TOTAL) begin
         st = cdhp_pkg::ST_TOO_LONG;
      end else begin
         st = cdhp_pkg::ST_OK;
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = st;
      if (st != cdhp_pkg::ST_SHORT && st != cdhp_pkg::ST_BAD_COMMAND) begin
         rsp_in.flags           = job.raw[4:1];
         rsp_in.channel         = job.raw[8:5];
         rsp_in.cmt_version     = job.raw[16:9];
         rsp_in.transaction_id  = job.raw[24:17];
         rsp_in.transaction_seq = job.raw[32:25];
         rsp_in.tenant          = job.raw[40:33];
         rsp_in.header_length   = hlen;
         rsp_in.client_span     = {off[0], len[0]};
         rsp_in.token_span      = {off[1], len[1]};
         rsp_in.stream_span     = {off[2], len[2]};
      end
   end

   always_comb begin
      max_len_in = max_len_ff;
      if (csr.we) begin
         case (csr.index)
            cdhp_pkg::CSR_MAX_FIELD_LEN: max_len_in = csr.wdata;
            default: ;
         endcase
      end
   end

   assign job_pop = job_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (job_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_len_ff   <= cdhp_pkg::MAX_FIELD_LEN_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         max_len_ff   <= max_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_ff.status;
   assign rsp.flags           = rsp_ff.flags;
   assign rsp.channel         = rsp_ff.channel;
   assign rsp.cmt_version     = rsp_ff.cmt_version;
   assign rsp.transaction_id  = rsp_ff.transaction_id;
   assign rsp.transaction_seq = rsp_ff.transaction_seq;
   assign rsp.tenant          = rsp_ff.tenant;
   assign rsp.header_length   = rsp_ff.header_length;
   assign rsp.client_span     = rsp_ff.client_span;
   assign rsp.token_span      = rsp_ff.token_span;
   assign rsp.stream_span     = rsp_ff.stream_span;

endmodule
